// ===== rtl/bgrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: shared package
// Types and fixed constants used by the sample interface and all block modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bgrc_pkg;

    // Fixed widths of the port fields.
    localparam int SAMPLE_W = 32;
    localparam int LEVEL_W  = 4;

    // Reset value of the maximum refinement level register.
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 4'd4;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Classification of one sample, produced by the front part.
    typedef struct packed {
        logic chk_left;  // compare with the sample one column earlier
        logic chk_up;    // compare with the sample one row earlier
        logic last;      // final sample of the tile
    } t_item_ctl;

endpackage

`default_nettype wire

// ===== rtl/bgrc_if.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: channel interfaces
// Valid/ready channels for the sample stream and the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample channel: one transaction per tile sample.
interface bgrc_samp_if import bgrc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [LEVEL_W-1:0]  tile_level;

    modport source (output valid, sample, tile_level, input ready);
    modport sink   (input valid, sample, tile_level, output ready);
endinterface

// Result channel: one transaction per completed tile.
interface bgrc_res_if ();
    logic valid;
    logic ready;
    logic refine;
    logic gradient_exceeded;

    modport source (output valid, refine, gradient_exceeded, input ready);
    modport sink   (input valid, refine, gradient_exceeded, output ready);
endinterface

`default_nettype wire

// ===== rtl/bgrc_front.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: front part
// Accepts samples, tracks the scan position, keeps the row delay line and
// the previous-column history, and classifies each sample for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module bgrc_front
    import bgrc_pkg::*;
#(
    parameter int TILE_SIDE  = 16,
    parameter int FREQ_COUNT = 4,
    parameter int SW         = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    bgrc_samp_if.sink          i_samp,
    input  wire logic          i_q_full,
    output logic               o_fv,
    output logic [SW-1:0]      o_sample,
    output logic [SW-1:0]      o_up_ref,
    output logic [SW-1:0]      o_left_ref,
    output logic [LEVEL_W-1:0] o_level,
    output t_item_ctl          o_ctl
);

    localparam int LINE_DEPTH = TILE_SIDE * FREQ_COUNT;
    localparam int RW = $clog2(TILE_SIDE);
    localparam int FW = (FREQ_COUNT > 1) ? $clog2(FREQ_COUNT) : 1;
    localparam int PW = $clog2(LINE_DEPTH);
    localparam logic [RW-1:0] SIDE_LAST = RW'(TILE_SIDE - 1);
    localparam logic [FW-1:0] FREQ_LAST = FW'(FREQ_COUNT - 1);

    logic [RW-1:0] r_row, n_row;
    logic [RW-1:0] r_col, n_col;
    logic [FW-1:0] r_freq, n_freq;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_fv;
    logic [SW-1:0] r_sample, r_up_ref, r_left_ref;
    logic [LEVEL_W-1:0] r_level;
    t_item_ctl     r_ctl;
    t_item_ctl     w_ctl;
    logic [SW-1:0] w_s;
    logic          w_acc;
    logic          w_row_end;

    // Row delay line and history of the current row, one entry per frequency.
    logic [SW-1:0] r_line [LINE_DEPTH];
    logic [SW-1:0] r_hist [FREQ_COUNT];

    // The stage takes a sample when it is empty or its content moves on.
    assign i_samp.ready = !r_fv || !i_q_full;
    assign w_acc        = i_samp.valid && i_samp.ready;
    assign w_s          = i_samp.sample[SW-1:0];

    // Classification from the current scan position.
    assign w_row_end    = (r_col == SIDE_LAST) && (r_freq == FREQ_LAST);
    always_comb begin
        w_ctl.chk_left = (r_col != '0) && (r_row != SIDE_LAST);
        w_ctl.chk_up   = (r_row != '0) && (r_col != SIDE_LAST);
        w_ctl.last     = w_row_end && (r_row == SIDE_LAST);
    end

    // Next scan position; the tile restarts after its last sample.
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_freq = r_freq;
        n_pos  = r_pos;
        if (w_acc) begin
            if (r_freq == FREQ_LAST) begin
                n_freq = '0;
                if (r_col == SIDE_LAST) begin
                    n_col = '0;
                    n_row = (r_row == SIDE_LAST) ? '0 : r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end else begin
                n_freq = r_freq + 1'b1;
            end
            n_pos = w_row_end ? '0 : r_pos + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_freq <= '0;
            r_pos  <= '0;
            r_fv   <= 1'b0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_freq <= n_freq;
            r_pos  <= n_pos;
            if (w_acc) begin
                r_fv <= 1'b1;
            end else if (!i_q_full) begin
                r_fv <= 1'b0;
            end
        end
    end

    // Delay line memory: the old entry is read as the new one is written.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_line[r_pos] <= w_s;
            r_up_ref      <= r_line[r_pos];
        end
    end

    // Stage payload and the short history giving the previous column.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_sample   <= w_s;
            r_left_ref <= r_hist[FREQ_COUNT-1];
            r_level    <= i_samp.tile_level;
            r_ctl      <= w_ctl;
            r_hist[0]  <= w_s;
            for (int i = 1; i < FREQ_COUNT; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    assign o_fv       = r_fv;
    assign o_sample   = r_sample;
    assign o_up_ref   = r_up_ref;
    assign o_left_ref = r_left_ref;
    assign o_level    = r_level;
    assign o_ctl      = r_ctl;

    // After the last sample of a tile the scan starts again at the origin.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_ctl.last |=> (r_row == '0) && (r_col == '0) && (r_pos == '0))
        else $error("scan position not cleared after the last sample");

    // The delay line position wraps exactly at the end of each row.
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !w_row_end |=> r_pos == $past(r_pos) + 1'b1)
        else $error("delay line position out of step with the scan");

endmodule

`default_nettype wire

// ===== rtl/bgrc_queue.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: item queue
// Small first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module bgrc_queue
    import bgrc_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);

    logic [W-1:0]      r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // The fill count never passes the depth and agrees with the pointers.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= QCNT_W'(QUEUE_DEPTH)) &&
        (QPTR_W'(r_cnt) == QPTR_W'(r_wp - r_rp)))
        else $error("queue fill count inconsistent");

endmodule

`default_nettype wire

// ===== rtl/bgrc_back.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: back part
// Tests each classified sample against its neighbours, keeps the sticky
// excess flag and registers the result of each tile.
// ----------------------------------------------------------------------------
`default_nettype none

module bgrc_back
    import bgrc_pkg::*;
#(
    parameter int SW = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_qv,
    input  wire logic [SW-1:0]      i_sample,
    input  wire logic [SW-1:0]      i_up_ref,
    input  wire logic [SW-1:0]      i_left_ref,
    input  wire logic [LEVEL_W-1:0] i_level,
    input  wire t_item_ctl          i_ctl,
    input  wire logic [LEVEL_W-1:0] i_max_level,
    output logic                    o_pop,
    bgrc_res_if.source              o_res
);

    logic          r_flag;
    logic          r_ov;
    logic          r_refine;
    logic          r_gex;
    logic [SW-1:0] w_d_left, w_d_up;
    logic          w_ex_left, w_ex_up, w_ex;
    logic          w_out_free;
    logic          w_pop;
    logic          w_gex;

    // Absolute differences and the quarter test 4*d > ref as d > ref/4.
    assign w_d_left  = (i_sample > i_left_ref) ? i_sample - i_left_ref
                                               : i_left_ref - i_sample;
    assign w_d_up    = (i_sample > i_up_ref) ? i_sample - i_up_ref
                                             : i_up_ref - i_sample;
    assign w_ex_left = i_ctl.chk_left && (w_d_left > (i_left_ref >> 2));
    assign w_ex_up   = i_ctl.chk_up && (w_d_up > (i_up_ref >> 2));
    assign w_ex      = w_ex_left || w_ex_up;
    assign w_gex     = r_flag || w_ex;

    // A final sample waits until the output register can take its result.
    assign w_out_free = !r_ov || o_res.ready;
    assign w_pop      = i_qv && (!i_ctl.last || w_out_free);
    assign o_pop      = w_pop;

    // Sticky flag and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_pop) begin
                r_flag <= i_ctl.last ? 1'b0 : w_gex;
            end
            if (w_pop && i_ctl.last) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_pop && i_ctl.last) begin
            r_gex    <= w_gex;
            r_refine <= w_gex && (i_level < i_max_level);
        end
    end

    assign o_res.valid             = r_ov;
    assign o_res.refine            = r_refine;
    assign o_res.gradient_exceeded = r_gex;

    // A completed tile leaves a cleared flag and a pending result.
    a_tile_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && i_ctl.last |=> !r_flag && o_res.valid)
        else $error("tile end did not clear the flag or raise a result");

    // Refinement is never reported without an excess.
    a_refine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.refine |-> o_res.gradient_exceeded)
        else $error("refine reported without a gradient excess");

endmodule

`default_nettype wire

// ===== rtl/block_gradient_refine_check.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: top level
// Streams the samples of one image tile and reports whether it needs to be
// split into four children.
// ----------------------------------------------------------------------------
// Samples of a TILE_SIDE x TILE_SIDE tile arrive with the frequency index
// varying fastest, one per transaction; the block takes one sample per cycle
// unless the queue is full. Each sample is checked against the same-frequency
// sample one column earlier (not in the last row) and one row earlier (not in
// the last column); a relative change above one quarter sets a sticky flag.
// After the last sample of a tile one result transaction carries that flag
// and refine = flag AND tile_level < max_refine_level. The rate is set by the
// row delay line, a memory of TILE_SIDE*FREQ_COUNT entries read and written
// once per sample. A four-entry queue decouples the sample side from the
// result side. The delay line needs no clearing after reset: no entry is used
// before it is written. The user must write max_refine_level only while no
// tile is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module block_gradient_refine_check
    import bgrc_pkg::*;
#(
    parameter int TILE_SIDE   = 16,
    parameter int FREQ_COUNT  = 4,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    bgrc_samp_if.sink               i_samp,
    bgrc_res_if.source              o_res,
    input  wire logic               i_cfg_we,
    input  wire logic [LEVEL_W-1:0] i_cfg_wdata
);

    localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CTL_W = $bits(t_item_ctl);
    localparam int QW = 3 * SW + LEVEL_W + CTL_W;

    logic [LEVEL_W-1:0] r_max_level;

    logic               w_fv;
    logic [SW-1:0]      w_f_sample, w_f_up, w_f_left;
    logic [LEVEL_W-1:0] w_f_level;
    t_item_ctl          w_f_ctl;
    logic               w_q_full, w_q_valid, w_q_pop;
    logic [QW-1:0]      w_q_in, w_q_out;
    logic [SW-1:0]      w_b_sample, w_b_up, w_b_left;
    logic [LEVEL_W-1:0] w_b_level;
    t_item_ctl          w_b_ctl;

    // Maximum refinement level register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RESET;
        end else if (i_cfg_we) begin
            r_max_level <= i_cfg_wdata;
        end
    end

    // Front part: scan position, delay line and classification.
    bgrc_front #(
        .TILE_SIDE  (TILE_SIDE),
        .FREQ_COUNT (FREQ_COUNT),
        .SW         (SW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_samp     (i_samp),
        .i_q_full   (w_q_full),
        .o_fv       (w_fv),
        .o_sample   (w_f_sample),
        .o_up_ref   (w_f_up),
        .o_left_ref (w_f_left),
        .o_level    (w_f_level),
        .o_ctl      (w_f_ctl)
    );

    // Queue between the two parts.
    assign w_q_in = {w_f_level, w_f_ctl, w_f_up, w_f_left, w_f_sample};

    bgrc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fv),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_out),
        .i_pop   (w_q_pop)
    );

    assign {w_b_level, w_b_ctl, w_b_up, w_b_left, w_b_sample} = w_q_out;

    // Back part: gradient tests, sticky flag and result register.
    bgrc_back #(
        .SW (SW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qv        (w_q_valid),
        .i_sample    (w_b_sample),
        .i_up_ref    (w_b_up),
        .i_left_ref  (w_b_left),
        .i_level     (w_b_level),
        .i_ctl       (w_b_ctl),
        .i_max_level (r_max_level),
        .o_pop       (w_q_pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== test/block_gradient_refine_check_checker.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: scoreboard
// Watches the sample, result and register ports of the block, keeps its own
// copy of the row delay line and scan position, works out the verdict of
// every completed tile and compares it with the result transactions in order.
// ----------------------------------------------------------------------------
`default_nettype none

module block_gradient_refine_check_checker
    import bgrc_pkg::*;
#(
    parameter int TILE_SIDE   = 16,
    parameter int FREQ_COUNT  = 4,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    bgrc_samp_if                    i_samp,
    bgrc_res_if                     i_res,
    input  wire logic               i_cfg_we,
    input  wire logic [LEVEL_W-1:0] i_cfg_wdata,
    output int                      o_errors,
    output int                      o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_ITEMS = TILE_SIDE * FREQ_COUNT;
    localparam int KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - KEEP_BITS);

    typedef struct {
        logic refine;
        logic gradient_exceeded;
    } t_tile_verdict;

    // Predicted state of the block.
    logic [SAMPLE_W-1:0] row_line [ROW_ITEMS];
    int unsigned         scan_row;
    int unsigned         scan_col;
    int unsigned         scan_freq;
    logic                any_excess;
    logic [LEVEL_W-1:0]  level_limit;
    t_tile_verdict       verdicts_q [$];

    int mismatch_count = 0;
    int tiles_open     = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = tiles_open;

    // Relative change above one quarter, tested exactly in integers.
    function automatic logic exceeds_quarter(logic [SAMPLE_W-1:0] cur,
                                             logic [SAMPLE_W-1:0] prev);
        logic [SAMPLE_W-1:0] diff;
        diff = (cur > prev) ? cur - prev : prev - cur;
        return diff > (prev >> 2);
    endfunction

    // Takes one sample into the scan and queues the verdict on the tile's end.
    function automatic void scan_sample(logic [SAMPLE_W-1:0] raw, logic [LEVEL_W-1:0] level);
        logic [SAMPLE_W-1:0] s;
        int unsigned         slot;
        logic                tile_end;
        t_tile_verdict       verdict;
        s    = raw & SAMPLE_MASK;
        slot = scan_col * FREQ_COUNT + scan_freq;

        // Same frequency one column earlier, in every row but the last.
        if (scan_col >= 1 && scan_row < TILE_SIDE - 1) begin
            if (exceeds_quarter(s, row_line[slot - FREQ_COUNT]))
                any_excess = 1'b1;
        end
        // Same frequency one row earlier, in every column but the last.
        if (scan_row >= 1 && scan_col < TILE_SIDE - 1) begin
            if (exceeds_quarter(s, row_line[slot]))
                any_excess = 1'b1;
        end
        row_line[slot] = s;

        tile_end = (scan_row == TILE_SIDE - 1) && (scan_col == TILE_SIDE - 1) &&
                   (scan_freq == FREQ_COUNT - 1);

        if (scan_freq + 1 < FREQ_COUNT) begin
            scan_freq = scan_freq + 1;
        end else begin
            scan_freq = 0;
            if (scan_col + 1 < TILE_SIDE) begin
                scan_col = scan_col + 1;
            end else begin
                scan_col = 0;
                scan_row = (scan_row + 1 < TILE_SIDE) ? scan_row + 1 : 0;
            end
        end

        if (tile_end) begin
            verdict.gradient_exceeded = any_excess;
            verdict.refine            = any_excess && (level < level_limit);
            verdicts_q.push_back(verdict);
            scan_row   = 0;
            scan_col   = 0;
            scan_freq  = 0;
            any_excess = 1'b0;
        end
    endfunction

    // Compares one result transaction with the oldest outstanding verdict.
    function automatic void check_verdict(logic refine, logic exceeded);
        t_tile_verdict want;
        if (verdicts_q.size() == 0) begin
            $error("result transaction with no completed tile outstanding");
            mismatch_count++;
            return;
        end
        want = verdicts_q.pop_front();
        if (refine !== want.refine) begin
            $error("refine: expected %0b, actual %0b", want.refine, refine);
            mismatch_count++;
        end
        if (exceeded !== want.gradient_exceeded) begin
            $error("gradient_exceeded: expected %0b, actual %0b",
                   want.gradient_exceeded, exceeded);
            mismatch_count++;
        end
    endfunction

    // Results are checked before new samples are taken, so a result that
    // comes too early finds no verdict waiting.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_row    = 0;
            scan_col    = 0;
            scan_freq   = 0;
            any_excess  = 1'b0;
            level_limit = MAX_LEVEL_RESET;
            verdicts_q.delete();
        end else begin
            if (i_res.valid && i_res.ready)
                check_verdict(i_res.refine, i_res.gradient_exceeded);
            if (i_samp.valid && i_samp.ready)
                scan_sample(i_samp.sample, i_samp.tile_level);
            if (i_cfg_we)
                level_limit = i_cfg_wdata;
        end
        tiles_open <= verdicts_q.size();
    end

endmodule

`default_nettype wire

// ===== test/block_gradient_refine_check_test.sv =====
// ----------------------------------------------------------------------------
// Tile gradient refinement check: testbench top
// Drives whole tiles of samples into the block with random gaps, stalls the
// result side at random, and changes the maximum refinement level between
// phases. A few directed tiles cover flat, zero and full-scale images and the
// exact quarter threshold; random tiles follow. The scoreboard beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module block_gradient_refine_check_test
    import bgrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_SIDE   = 16;
    localparam int FREQ_COUNT  = 4;
    localparam int SAMPLE_BITS = 32;
    localparam int TILE_ITEMS  = TILE_SIDE * TILE_SIDE * FREQ_COUNT;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int DRAIN_WAIT  = 16;
    localparam int NO_SPIKE    = -1;

    typedef enum {TILE_FLAT, TILE_SMOOTH, TILE_NOISE} t_tile_style;

    // Gap patterns of the sample side, chosen per tile.
    typedef enum {GAPS_NONE, GAPS_EVERY, GAPS_SPARSE} t_gap_mode;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LEVEL_W-1:0] cfg_wdata;
    int                 errors;
    int                 pending;
    int                 cycle_count = 0;
    t_gap_mode          gap_mode;

    bgrc_samp_if samp_ch ();
    bgrc_res_if  res_ch ();

    block_gradient_refine_check #(
        .TILE_SIDE   (TILE_SIDE),
        .FREQ_COUNT  (FREQ_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_samp      (samp_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    block_gradient_refine_check_checker #(
        .TILE_SIDE   (TILE_SIDE),
        .FREQ_COUNT  (FREQ_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_samp      (samp_ch),
        .i_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: a random stall before each transaction, sometimes none.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                @(negedge clk) res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Offers one sample after a gap drawn from the current pattern.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value,
                               input logic [LEVEL_W-1:0] level);
        int gap;
        case (gap_mode)
            GAPS_NONE:  gap = 0;
            GAPS_EVERY: gap = $urandom_range(0, 16);
            default:    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
        if (gap > 0) begin
            @(negedge clk) samp_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samp_ch.valid      <= 1'b1;
        samp_ch.sample     <= value;
        samp_ch.tile_level <= level;
        do @(posedge clk); while (!samp_ch.ready);
    endtask

    // Streams one tile; a single sample may be replaced by a spike value.
    task automatic send_tile(input t_tile_style style, input logic [SAMPLE_W-1:0] base,
                             input int spike_idx, input logic [SAMPLE_W-1:0] spike_val,
                             input logic [LEVEL_W-1:0] level, input bit level_varies);
        logic [SAMPLE_W-1:0] value;
        logic [LEVEL_W-1:0]  lvl;
        gap_mode = t_gap_mode'($urandom_range(0, 2));
        for (int idx = 0; idx < TILE_ITEMS; idx++) begin
            case (style)
                TILE_FLAT:   value = base;
                TILE_SMOOTH: value = base + $urandom_range(0, base >> 5);
                default:     value = $urandom;
            endcase
            if (idx == spike_idx)
                value = spike_val;
            // Only the level of the last sample counts.
            lvl = (level_varies && idx != TILE_ITEMS - 1) ? LEVEL_W'($urandom) : level;
            send_sample(value, lvl);
        end
    endtask

    // One tile of random shape and content.
    task automatic random_tile();
        int                  pick;
        int                  spike_idx;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] spike_val;
        t_tile_style         style;
        pick      = $urandom_range(0, 9);
        spike_idx = ($urandom_range(0, 3) == 0) ? NO_SPIKE : $urandom_range(0, TILE_ITEMS - 1);
        spike_val = $urandom;
        if (pick < 5) begin
            // Gentle image that only a spike can push over the threshold.
            style = TILE_SMOOTH;
            base  = $urandom_range(32'h7FFF_FFFF, 32'h0010_0000);
        end else if (pick < 8) begin
            // Flat image with a spike at, or one above, the quarter threshold.
            style     = TILE_FLAT;
            base      = $urandom >> $urandom_range(1, 31);
            spike_val = base + (base >> 2) + $urandom_range(0, 1);
        end else begin
            style = TILE_NOISE;
            base  = '0;
        end
        send_tile(style, base, spike_idx, spike_val, LEVEL_W'($urandom),
                  $urandom_range(0, 4) == 0);
    endtask

    // Waits until every tile has reported and the pipeline has emptied.
    task automatic drain();
        @(negedge clk) samp_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Register write; only called once the block is idle.
    task automatic write_level_limit(input logic [LEVEL_W-1:0] limit);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin
        int                 interior;
        logic [LEVEL_W-1:0] limits [6];
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        samp_ch.valid      = 1'b0;
        samp_ch.sample     = '0;
        samp_ch.tile_level = '0;
        gap_mode           = GAPS_NONE;
        interior           = ((5 * TILE_SIDE) + 7) * FREQ_COUNT + 2;
        limits             = '{4'd15, 4'd0, 4'd1, 4'd8, LEVEL_W'($urandom), LEVEL_W'($urandom)};

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed tiles under the reset value of the level limit.
        // All-zero image: no change at all, so nothing exceeds.
        send_tile(TILE_FLAT, '0, NO_SPIKE, '0, 4'd0, 1'b0);
        // Zero reference with a change of one counts as an excess.
        send_tile(TILE_FLAT, '0, interior, 32'd1, 4'd0, 1'b0);
        // Full-scale flat image.
        send_tile(TILE_FLAT, '1, NO_SPIKE, '0, 4'd15, 1'b0);
        // Exactly one quarter is not an excess; one more is.
        send_tile(TILE_FLAT, 32'd1000, interior, 32'd1250, 4'd3, 1'b0);
        send_tile(TILE_FLAT, 32'd1000, interior, 32'd1251, 4'd3, 1'b0);
        // Level equal to the limit is never refined.
        send_tile(TILE_FLAT, 32'd1000, interior, 32'd1251, 4'd4, 1'b0);
        // A spike on the first sample, then one on the last sample.
        send_tile(TILE_FLAT, 32'h8000_0000, 0, 32'hFFFF_FFFF, 4'd1, 1'b0);
        send_tile(TILE_FLAT, 32'h8000_0000, TILE_ITEMS - 1, 32'hFFFF_FFFF, 4'd1, 1'b0);
        // Noisy image whose level changes within the tile.
        send_tile(TILE_NOISE, '0, NO_SPIKE, '0, 4'd1, 1'b1);
        drain();

        // Random phases, each under a new level limit.
        foreach (limits[p]) begin
            write_level_limit(limits[p]);
            repeat (4) random_tile();
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bgrc_pkg.sv
rtl/bgrc_if.sv
rtl/bgrc_front.sv
rtl/bgrc_queue.sv
rtl/bgrc_back.sv
rtl/block_gradient_refine_check.sv
test/block_gradient_refine_check_checker.sv
test/block_gradient_refine_check_test.sv
